@@ sv/nbsc_pkg.sv @@
package nbsc_pkg;

    localparam int MAX_DEPTH = 8;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // command classes
    localparam logic [3:0] OP_OTHER        = 4'd0;
    localparam logic [3:0] OP_IF           = 4'd1;
    localparam logic [3:0] OP_WHILE        = 4'd2;
    localparam logic [3:0] OP_FUNCTION     = 4'd3;
    localparam logic [3:0] OP_END_IF       = 4'd4;
    localparam logic [3:0] OP_END_WHILE    = 4'd5;
    localparam logic [3:0] OP_END_FUNCTION = 4'd6;
    localparam logic [3:0] OP_ELSE         = 4'd7;
    localparam logic [3:0] OP_BREAK        = 4'd8;
    localparam logic [3:0] OP_RETURN       = 4'd9;
    localparam logic [3:0] OP_END          = 4'd10;

    // block kinds held on the stack
    localparam logic [1:0] KIND_IF       = 2'd0;
    localparam logic [1:0] KIND_WHILE    = 2'd1;
    localparam logic [1:0] KIND_FUNCTION = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TOO_DEEP    = 4'd1;
    localparam logic [3:0] ST_UNMATCHED   = 4'd2;  // plus kind
    localparam logic [3:0] ST_STRAY_ELSE  = 4'd5;
    localparam logic [3:0] ST_DOUBLE_ELSE = 4'd6;
    localparam logic [3:0] ST_BREAK       = 4'd7;
    localparam logic [3:0] ST_RETURN      = 4'd8;
    localparam logic [3:0] ST_UNCLOSED    = 4'd9;  // plus kind
    localparam logic [3:0] ST_FAILED      = 4'd12;

    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] line_number;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] error_line;
        logic        verdict;
    } t_out;

    typedef struct packed {
        logic        push;
        logic [1:0]  kind;
        logic [15:0] line;
        logic        pop;
        logic        mark_else;
        logic        clear;
    } t_stk_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [1:0]       top_kind;
        logic [15:0]      top_line;
        logic             top_else;
        logic             any_while;
        logic             any_func;
    } t_stk_view;

endpackage

@@ sv/nbsc_stack.sv @@
module nbsc_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nbsc_pkg::t_stk_cmd  i_cmd,
    output nbsc_pkg::t_stk_view o_view
);

    logic [1:0]                 r_kind [nbsc_pkg::MAX_DEPTH];
    logic [15:0]                r_line [nbsc_pkg::MAX_DEPTH];
    logic                       r_else [nbsc_pkg::MAX_DEPTH];
    logic [nbsc_pkg::CNT_W-1:0] r_count;
    logic [nbsc_pkg::CNT_W-1:0] n_count;
    logic [nbsc_pkg::CNT_W-1:0] top_cnt;
    logic [nbsc_pkg::IDX_W-1:0] push_idx;
    logic [nbsc_pkg::IDX_W-1:0] top_idx;
    logic [nbsc_pkg::MAX_DEPTH-1:0] is_while;
    logic [nbsc_pkg::MAX_DEPTH-1:0] is_func;

    assign top_cnt  = r_count - nbsc_pkg::CNT_W'(1);
    assign push_idx = r_count[nbsc_pkg::IDX_W-1:0];
    assign top_idx  = top_cnt[nbsc_pkg::IDX_W-1:0];

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + nbsc_pkg::CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = top_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_kind[push_idx] <= i_cmd.kind;
            r_line[push_idx] <= i_cmd.line;
            r_else[push_idx] <= 1'b0;
        end else if (i_cmd.mark_else) begin
            r_else[top_idx] <= 1'b1;
        end
    end

    // presence of a kind anywhere in the live part of the stack
    always_comb begin
        for (int i = 0; i < nbsc_pkg::MAX_DEPTH; i++) begin
            is_while[i] = (nbsc_pkg::CNT_W'(i) < r_count)
                          && (r_kind[i] == nbsc_pkg::KIND_WHILE);
            is_func[i]  = (nbsc_pkg::CNT_W'(i) < r_count)
                          && (r_kind[i] == nbsc_pkg::KIND_FUNCTION);
        end
    end

    always_comb begin
        o_view.count     = r_count;
        o_view.top_kind  = r_kind[top_idx];
        o_view.top_line  = r_line[top_idx];
        o_view.top_else  = r_else[top_idx];
        o_view.any_while = |is_while;
        o_view.any_func  = |is_func;
    end

endmodule

@@ sv/nbsc_ctrl.sv @@
module nbsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  nbsc_pkg::t_in       i_item,
    input  nbsc_pkg::t_stk_view i_view,
    output nbsc_pkg::t_stk_cmd  o_cmd,
    output nbsc_pkg::t_out      o_res
);

    logic [3:0]  r_err_code;
    logic [15:0] r_err_line;
    logic [3:0]  n_err_code;
    logic [15:0] n_err_line;
    logic [3:0]  chk;
    logic        empty;
    logic        full;
    logic [1:0]  open_kind;
    logic [1:0]  close_kind;
    nbsc_pkg::t_stk_cmd cmd;

    assign empty      = (i_view.count == '0);
    assign full       = (i_view.count == nbsc_pkg::CNT_W'(nbsc_pkg::MAX_DEPTH));
    assign open_kind  = 2'(i_item.op - nbsc_pkg::OP_IF);
    assign close_kind = 2'(i_item.op - nbsc_pkg::OP_END_IF);

    always_comb begin
        chk            = nbsc_pkg::ST_OK;
        cmd            = '0;
        cmd.kind       = open_kind;
        cmd.line       = i_item.line_number;
        o_res.status     = nbsc_pkg::ST_OK;
        o_res.error_line = '0;
        o_res.verdict    = 1'b0;
        n_err_code     = r_err_code;
        n_err_line     = r_err_line;

        unique case (i_item.op) inside
            nbsc_pkg::OP_IF, nbsc_pkg::OP_WHILE, nbsc_pkg::OP_FUNCTION: begin
                if (full) chk = nbsc_pkg::ST_TOO_DEEP;
                else      cmd.push = 1'b1;
            end
            nbsc_pkg::OP_END_IF, nbsc_pkg::OP_END_WHILE,
            nbsc_pkg::OP_END_FUNCTION: begin
                if (empty || i_view.top_kind != close_kind)
                    chk = nbsc_pkg::ST_UNMATCHED + {2'b00, close_kind};
                else
                    cmd.pop = 1'b1;
            end
            nbsc_pkg::OP_ELSE: begin
                if (empty || i_view.top_kind != nbsc_pkg::KIND_IF)
                    chk = nbsc_pkg::ST_STRAY_ELSE;
                else if (i_view.top_else)
                    chk = nbsc_pkg::ST_DOUBLE_ELSE;
                else
                    cmd.mark_else = 1'b1;
            end
            nbsc_pkg::OP_BREAK: begin
                if (!i_view.any_while) chk = nbsc_pkg::ST_BREAK;
            end
            nbsc_pkg::OP_RETURN: begin
                if (!i_view.any_func) chk = nbsc_pkg::ST_RETURN;
            end
            default: chk = nbsc_pkg::ST_OK;
        endcase

        if (i_item.op == nbsc_pkg::OP_END) begin
            cmd           = '0;
            cmd.clear     = 1'b1;
            o_res.verdict = 1'b1;
            if (r_err_code != nbsc_pkg::ST_OK) begin
                o_res.status     = r_err_code;
                o_res.error_line = r_err_line;
            end else if (!empty) begin
                o_res.status     = nbsc_pkg::ST_UNCLOSED + {2'b00, i_view.top_kind};
                o_res.error_line = i_view.top_line;
            end
            n_err_code = nbsc_pkg::ST_OK;
            n_err_line = '0;
        end else if (r_err_code != nbsc_pkg::ST_OK) begin
            // latched error: stack left alone until end of script
            cmd              = '0;
            o_res.status     = nbsc_pkg::ST_FAILED;
            o_res.error_line = r_err_line;
        end else if (chk != nbsc_pkg::ST_OK) begin
            o_res.status     = chk;
            o_res.error_line = i_item.line_number;
            n_err_code       = chk;
            n_err_line       = i_item.line_number;
        end

        o_cmd           = cmd;
        o_cmd.push      = cmd.push && i_adv;
        o_cmd.pop       = cmd.pop && i_adv;
        o_cmd.mark_else = cmd.mark_else && i_adv;
        o_cmd.clear     = cmd.clear && i_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_code <= nbsc_pkg::ST_OK;
            r_err_line <= '0;
        end else if (i_adv) begin
            r_err_code <= n_err_code;
            r_err_line <= n_err_line;
        end
    end

endmodule

@@ sv/nested_block_structure_checker.sv @@
// An accepted item passes from the input register to the result register driving o_out_data.
// Throughput: one item per cycle when not stalled; the input register feeds the stack update
// and result register directly, the stack top and kind flags being read in that cycle.
// Reset (i_rst_n low, synchronous): both registers empty, stack count zero,
// error latch cleared. Stack contents are not cleared.
module nested_block_structure_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nbsc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output nbsc_pkg::t_out o_out_data
);

    logic                r_in_valid;
    nbsc_pkg::t_in       r_in;
    logic                r_out_valid;
    nbsc_pkg::t_out      r_out;
    logic                adv;
    nbsc_pkg::t_stk_cmd  stk_cmd;
    nbsc_pkg::t_stk_view stk_view;
    nbsc_pkg::t_out      res;

    // item moves from input register to result register
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    nbsc_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_view  (stk_view)
    );

    nbsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_view  (stk_view),
        .o_cmd   (stk_cmd),
        .o_res   (res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
